@@ rtl/core/array_stack_with_reverse_assert.svh @@
// Assertion macros for the array stack checker.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ARRAY_STACK_WITH_REVERSE_ASSERT_SVH
`define ARRAY_STACK_WITH_REVERSE_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define ASR_CHECK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASR_NEVER(name, cond, msg) \
    `ASR_CHECK(name, !(cond), msg)

`endif

@@ rtl/core/asr_pkg.sv @@
// Shared types and constants for the array stack with reverse.
// Used by the controller, the datapath, the top level and the checker.
package asr_pkg;

    localparam int DATA_W          = 32;
    localparam int DEPTH_W         = 8;
    localparam int STACK_DEPTH_DEF = 128;

    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;

    typedef enum logic [1:0] {
        FN_PUSH = 2'd0,
        FN_POP  = 2'd1,
        FN_PEEK = 2'd2,
        FN_REV  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SWAP_RD,
        S_SWAP_LO,
        S_SWAP_HI
    } t_state;

    typedef enum logic [1:0] {
        OS_ZERO,
        OS_EMPTY,
        OS_READ
    } t_out_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     push;       // write data_in at the top, count up
        logic     rd_top;     // read the top entry
        logic     pop_dec;    // count down
        logic     sw_init;    // set the swap pointers to both ends
        logic     sw_rd;      // read both swap entries
        logic     sw_wr_lo;   // write the high entry into the low slot
        logic     sw_wr_hi;   // write the low entry into the high slot, step pointers
        logic     load;       // load the result register
        t_out_sel out_sel;
        t_status  out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic short_stack;    // fewer than two entries
        logic more_pairs;     // another swap pair follows the current one
    } t_dp_stat;

endpackage

@@ rtl/core/array_stack_with_reverse.sv @@
// Channel  | Valid       | Stall        | Payload
// ---------+-------------+--------------+-------------------------------------
// in       | i_in_valid  | o_in_stall   | i_func, i_data_in
// out      | o_out_valid | i_out_stall  | o_value_out, o_status, o_depth
//
// Push, and pop or peek of an empty stack, load the result as the command is taken.
// Pop and peek of a held entry pass through S_READ: the entry memory read is registered.
// Reverse of N entries sets the swap pointers, then for floor(N/2) pairs: read pair,
// write low, write high on the single write port. Under two entries: result load only.
// Reset is synchronous and active low; it empties the stack, memory is not cleared.
// A new command is taken while a result waits only if that result leaves this cycle.
//
// Top level of the array stack with reverse; joins asr_ctrl and asr_dpath.
// Depends on asr_pkg.
module array_stack_with_reverse
    import asr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_func,
    input  logic signed [DATA_W-1:0] i_data_in,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [1:0]               o_status,
    output logic [DEPTH_W-1:0]       o_depth
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    asr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    asr_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_in   (i_data_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_depth     (o_depth)
    );

endmodule

@@ rtl/core/asr_ctrl.sv @@
// Controller state machine for the array stack with reverse.
// Depends on asr_pkg; drives the datapath through t_dp_cmd.
module asr_ctrl
    import asr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;
    t_func  func;

    assign func     = t_func'(i_func);
    assign out_free = !r_out_valid || !i_out_stall;
    assign accept   = (r_state == S_IDLE) && out_free && i_in_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (func)
                        FN_POP, FN_PEEK: begin
                            if (!i_stat.empty) n_state = S_READ;
                        end
                        FN_REV: begin
                            if (!i_stat.short_stack) n_state = S_SWAP_RD;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ:    n_state = S_IDLE;
            S_SWAP_RD: n_state = S_SWAP_LO;
            S_SWAP_LO: n_state = S_SWAP_HI;
            S_SWAP_HI: n_state = i_stat.more_pairs ? S_SWAP_RD : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.out_sel    = OS_ZERO;
        o_cmd.out_status = ST_OK;
        o_in_stall       = !((r_state == S_IDLE) && out_free);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (func)
                        FN_PUSH: begin
                            o_cmd.load = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = ST_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        FN_POP, FN_PEEK: begin
                            if (i_stat.empty) begin
                                o_cmd.load       = 1'b1;
                                o_cmd.out_sel    = OS_EMPTY;
                                o_cmd.out_status = ST_EMPTY;
                            end else begin
                                o_cmd.rd_top  = 1'b1;
                                o_cmd.pop_dec = (func == FN_POP);
                            end
                        end
                        FN_REV: begin
                            if (i_stat.short_stack) begin
                                o_cmd.load = 1'b1;
                            end else begin
                                o_cmd.sw_init = 1'b1;
                            end
                        end
                        default: o_cmd.load = 1'b0;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.load    = 1'b1;
                o_cmd.out_sel = OS_READ;
            end
            S_SWAP_RD: o_cmd.sw_rd    = 1'b1;
            S_SWAP_LO: o_cmd.sw_wr_lo = 1'b1;
            S_SWAP_HI: begin
                o_cmd.sw_wr_hi = 1'b1;
                o_cmd.load     = !i_stat.more_pairs;
            end
            default: o_cmd.load = 1'b0;
        endcase
    end

    // Hold a result until the transfer completes.
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (o_cmd.load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/asr_dpath.sv @@
// Datapath for the array stack with reverse: entry memory, count, swap
// pointers and the result register. Depends on asr_pkg.
module asr_dpath
    import asr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic signed [DATA_W-1:0] i_data_in,
    input  t_dp_cmd                  i_cmd,
    output t_dp_stat                 o_stat,
    output logic signed [DATA_W-1:0] o_value_out,
    output logic [1:0]               o_status,
    output logic [DEPTH_W-1:0]       o_depth
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0]  r_count, n_count;
    logic [AW-1:0]     r_lo, r_hi;
    logic [DATA_W-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]     top_addr;
    logic [AW-1:0]     rd_a_addr;
    logic              we;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [AW:0]       span;

    logic [DATA_W-1:0]  r_value;
    logic [1:0]         r_status;
    logic [DEPTH_W-1:0] r_depth;

    assign top_addr  = AW'(r_count - CNT_W'(1));
    assign rd_a_addr = i_cmd.rd_top ? top_addr : r_lo;
    assign span      = {1'b0, r_hi} - {1'b0, r_lo};

    assign o_stat.empty       = (r_count == '0);
    assign o_stat.full        = (r_count == CNT_W'(STACK_DEPTH));
    assign o_stat.short_stack = (r_count < CNT_W'(2));
    assign o_stat.more_pairs  = (span > (AW+1)'(2));

    always_comb begin
        n_count = r_count;
        if (i_cmd.push)    n_count = r_count + CNT_W'(1);
        if (i_cmd.pop_dec) n_count = r_count - CNT_W'(1);
    end

    always_comb begin
        we      = i_cmd.push || i_cmd.sw_wr_lo || i_cmd.sw_wr_hi;
        wr_addr = AW'(r_count);
        wr_data = i_data_in;
        if (i_cmd.sw_wr_lo) begin
            wr_addr = r_lo;
            wr_data = r_rd_b;
        end else if (i_cmd.sw_wr_hi) begin
            wr_addr = r_hi;
            wr_data = r_rd_a;
        end
    end

    // One write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        r_rd_a <= mem[rd_a_addr];
        r_rd_b <= mem[r_hi];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Walk the pointers inward one pair at a time.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sw_init) begin
            r_lo <= '0;
            r_hi <= top_addr;
        end else if (i_cmd.sw_wr_hi) begin
            r_lo <= r_lo + AW'(1);
            r_hi <= r_hi - AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            case (i_cmd.out_sel)
                OS_EMPTY: r_value <= MOST_NEG;
                OS_READ:  r_value <= r_rd_a;
                default:  r_value <= '0;
            endcase
            r_status <= i_cmd.out_status;
            r_depth  <= DEPTH_W'(n_count);
        end
    end

    assign o_value_out = r_value;
    assign o_status    = r_status;
    assign o_depth     = r_depth;

endmodule

@@ rtl/core/asr_checker.sv @@
// Port-level checks for the array stack with reverse, bound to the top level.
// Depends on asr_pkg and array_stack_with_reverse_assert.svh.
`include "array_stack_with_reverse_assert.svh"

module asr_checker
    import asr_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic [1:0]               i_func,
    input logic signed [DATA_W-1:0] i_data_in,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_value_out,
    input logic [1:0]               o_status,
    input logic [DEPTH_W-1:0]       o_depth
);

    `ASR_CHECK(a_in_hold,
        (i_in_valid && o_in_stall) |=>
            (i_in_valid && $stable(i_func) && $stable(i_data_in)),
        "stalled command changed")
    `ASR_CHECK(a_out_hold, (o_out_valid && i_out_stall) |=> o_out_valid,
        "result dropped while stalled")
    `ASR_CHECK(a_empty_val,
        (o_out_valid && o_status == ST_EMPTY) |->
            (o_value_out == MOST_NEG && o_depth == '0),
        "empty result malformed")
    `ASR_CHECK(a_ovf_val,
        (o_out_valid && o_status == ST_OVERFLOW) |-> (o_value_out == '0),
        "overflow result carries data")
    `ASR_NEVER(a_no_bad_status,
        o_out_valid && o_status != ST_OK && o_status != ST_OVERFLOW && o_status != ST_EMPTY,
        "undefined status code")

endmodule

bind array_stack_with_reverse asr_checker u_asr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_func      (i_func),
    .i_data_in   (i_data_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value_out (o_value_out),
    .o_status    (o_status),
    .o_depth     (o_depth)
);

@@ bench/array_stack_with_reverse_tb.sv @@
// Self-checking bench for array_stack_with_reverse: push, pop, peek and reverse commands.
// Predicts every result with its own stack model and checks o_value_out, o_status, o_depth.
// Depends on asr_pkg and the array_stack_with_reverse RTL.
module array_stack_with_reverse_tb
    import asr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int N_ITEMS     = 1350;
    localparam int MAX_GAP     = 18;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 250;

    typedef struct {
        t_func             func;
        logic [DATA_W-1:0] data;
        int                gap;
        bit                drain;
    } t_stack_cmd;

    typedef struct {
        logic [DATA_W-1:0]  value;
        t_status            status;
        logic [DEPTH_W-1:0] depth;
    } t_stack_result;

    logic                     i_clk;
    logic                     i_rst_n     = 1'b0;
    logic                     i_in_valid  = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_func      = FN_PUSH;
    logic signed [DATA_W-1:0] i_data_in   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_value_out;
    logic [1:0]               o_status;
    logic [DEPTH_W-1:0]       o_depth;

    array_stack_with_reverse #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_data_in  (i_data_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_value_out(o_value_out),
        .o_status   (o_status),
        .o_depth    (o_depth)
    );

    t_stack_cmd        cmd_queue[$];
    t_stack_result     expected_results[$];
    logic [DATA_W-1:0] model_mem [STACK_DEPTH];
    int                model_count = 0;

    int   mismatch_count = 0;
    int   items_accepted = 0;
    int   results_seen   = 0;
    int   total_items    = 0;
    logic long_hold      = 1'b0;

    // stimulus generation state
    int gen_depth = 0;
    bit gen_calm  = 1'b0;

    // driver and monitor state
    t_stack_cmd    next_cmd;
    int            tx_wait      = 0;
    int            rx_wait      = 0;
    bit            rx_calm      = 1'b0;
    int            rx_calm_left = 0;
    t_stack_result want;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #18_000_000;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Apply one command to the model stack and queue the result it must give.
    function automatic void predict_stack_result(input t_func f, input logic [DATA_W-1:0] d);
        t_stack_result     r;
        int                lo;
        int                hi;
        logic [DATA_W-1:0] tmp;
        r.value  = '0;
        r.status = ST_OK;
        case (f)
            FN_PUSH: begin
                if (model_count >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_mem[model_count] = d;
                    model_count++;
                end
            end
            FN_POP: begin
                if (model_count == 0) begin
                    r.value  = MOST_NEG;
                    r.status = ST_EMPTY;
                end else begin
                    model_count--;
                    r.value = model_mem[model_count];
                end
            end
            FN_PEEK: begin
                if (model_count == 0) begin
                    r.value  = MOST_NEG;
                    r.status = ST_EMPTY;
                end else begin
                    r.value = model_mem[model_count-1];
                end
            end
            default: begin
                lo = 0;
                hi = model_count - 1;
                while (lo < hi) begin
                    tmp           = model_mem[lo];
                    model_mem[lo] = model_mem[hi];
                    model_mem[hi] = tmp;
                    lo++;
                    hi--;
                end
            end
        endcase
        r.depth = DEPTH_W'(model_count);
        expected_results.push_back(r);
    endfunction

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return MOST_NEG;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_cmd(input t_func f, input logic [DATA_W-1:0] d, input bit drain);
        t_stack_cmd c;
        c.func  = f;
        c.data  = d;
        c.gap   = gen_calm ? 0 : $urandom_range(0, MAX_GAP);
        c.drain = drain;
        cmd_queue.push_back(c);
        if (f == FN_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
        if (f == FN_POP && gen_depth > 0) gen_depth--;
    endtask

    task automatic build_commands();
        int    seg;
        int    kind;
        int    len;
        int    r;
        int    k;
        bit    first;
        t_func f;
        seg = 0;
        // empty-stack corners, single-entry reverse, extreme values, reverse order check
        queue_cmd(FN_PEEK, rand_word(), 1'b0);
        queue_cmd(FN_POP,  rand_word(), 1'b0);
        queue_cmd(FN_REV,  rand_word(), 1'b0);
        queue_cmd(FN_PUSH, MOST_NEG, 1'b0);
        queue_cmd(FN_PEEK, '0, 1'b0);
        queue_cmd(FN_REV,  '1, 1'b0);
        queue_cmd(FN_PEEK, '0, 1'b0);
        queue_cmd(FN_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_cmd(FN_PUSH, '0, 1'b0);
        queue_cmd(FN_PUSH, '1, 1'b0);
        queue_cmd(FN_PUSH, 32'h0000_0001, 1'b0);
        queue_cmd(FN_PEEK, '0, 1'b0);
        queue_cmd(FN_REV,  '0, 1'b0);
        queue_cmd(FN_PEEK, '0, 1'b0);
        queue_cmd(FN_PUSH, 32'h5555_5555, 1'b0);
        queue_cmd(FN_PUSH, 32'hAAAA_AAAA, 1'b0);
        queue_cmd(FN_REV,  '0, 1'b0);
        for (k = 0; k < 7; k++) queue_cmd(FN_POP, rand_word(), 1'b0);
        queue_cmd(FN_POP, rand_word(), 1'b0);

        while (cmd_queue.size() < N_ITEMS) begin
            gen_calm = ($urandom_range(0, 3) == 0);
            first    = (seg == 0) || ($urandom_range(0, 5) == 0);
            kind     = (seg == 2 || seg == 9) ? 0 : $urandom_range(0, 11);
            if (kind == 0) begin
                // fill to the top, overflow, reverse a full stack
                len = STACK_DEPTH - gen_depth + $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    queue_cmd(FN_PUSH, rand_word(), first);
                    first = 1'b0;
                end
                queue_cmd(FN_PEEK, rand_word(), 1'b0);
                queue_cmd(FN_REV,  rand_word(), 1'b0);
                queue_cmd(FN_PEEK, rand_word(), 1'b0);
                queue_cmd(FN_POP,  rand_word(), 1'b0);
            end else if (kind == 1) begin
                // empty out and keep reading
                len = gen_depth + $urandom_range(1, 3);
                for (k = 0; k < len; k++) begin
                    f = ($urandom_range(0, 4) == 0) ? FN_PEEK : FN_POP;
                    queue_cmd(f, rand_word(), first);
                    first = 1'b0;
                end
                queue_cmd(FN_REV, rand_word(), 1'b0);
            end else begin
                len = $urandom_range(20, 60);
                for (k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (kind < 6) r = r / 2;
                    if (r < 40)      f = FN_PUSH;
                    else if (r < 65) f = FN_POP;
                    else if (r < 85) f = FN_PEEK;
                    else             f = FN_REV;
                    queue_cmd(f, rand_word(), first);
                    first = 1'b0;
                end
            end
            seg++;
        end
        total_items = cmd_queue.size();
    endtask

    // Driver: record every transfer, then present the next command after its gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_stack_result(t_func'(i_func), i_data_in);
                items_accepted++;
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (cmd_queue.size() == 0 ||
                    (cmd_queue[0].drain && !long_hold && expected_results.size() != 0)) begin
                    i_in_valid <= 1'b0;
                end else if (tx_wait < cmd_queue[0].gap) begin
                    tx_wait++;
                    i_in_valid <= 1'b0;
                end else begin
                    next_cmd = cmd_queue.pop_front();
                    tx_wait = 0;
                    i_in_valid <= 1'b1;
                    i_func     <= next_cmd.func;
                    i_data_in  <= next_cmd.data;
                end
            end
        end
    end

    // Monitor: check each transfer against the oldest prediction, then draw the next stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result value=%h status=%0d depth=%0d",
                        o_value_out, o_status, o_depth));
                end else begin
                    want = expected_results.pop_front();
                    if (o_value_out !== want.value)
                        report_mismatch($sformatf("value_out got %h want %h",
                            o_value_out, want.value));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            o_status, want.status));
                    if (o_depth !== want.depth)
                        report_mismatch($sformatf("depth got %0d want %0d",
                            o_depth, want.depth));
                end
                if (rx_calm_left == 0) begin
                    rx_calm      = ($urandom_range(0, 2) == 0);
                    rx_calm_left = $urandom_range(20, 80);
                end else begin
                    rx_calm_left--;
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            i_out_stall <= long_hold || (rx_wait != 0);
        end
    end

    // Hold the output off long enough that the block backs up into its input.
    initial begin
        wait (results_seen >= HOLD_AFTER);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    initial begin
        build_commands();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (items_accepted < total_items || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
